>>> rtl/hre_pkg.sv
// Shared constants, types and encoding functions for the Hamming row encoder.
`timescale 1ns / 1ps
package hre_pkg;

  localparam int MAX_ROW_BYTES = 7;
  localparam int RB_W          = 3;
  localparam int BYTE_W        = 8;
  localparam int ROW_W         = MAX_ROW_BYTES * BYTE_W;
  localparam int PAR_W         = 6;
  localparam int CW_W          = ROW_W + PAR_W;
  localparam int BITS_W        = 6;
  localparam int PAD_W         = 3;
  localparam logic [BYTE_W-1:0] FILL_BYTE = 8'h7E;

  // One finished row on its way to the encoder: data bits left aligned,
  // the first data bit in the top bit.
  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [BITS_W-1:0] total_bits;
    logic [PAD_W-1:0]  pad_bytes;
  } job_t;

  // A register value of zero acts as one byte; values above the limit clamp.
  function automatic logic [RB_W-1:0] eff_row_bytes(input logic [RB_W-1:0] v);
    logic [RB_W-1:0] rb;
    rb = v;
    if (rb == '0) rb = RB_W'(1);
    if (rb > RB_W'(MAX_ROW_BYTES)) rb = RB_W'(MAX_ROW_BYTES);
    return rb;
  endfunction

  // Data bits plus the least number of check bits that covers them.
  function automatic logic [BITS_W-1:0] codeword_len(input logic [RB_W-1:0] rb);
    logic [BITS_W-1:0] len;
    unique case (rb)
      3'd1:    len = 6'd12;
      3'd2:    len = 6'd21;
      3'd3:    len = 6'd29;
      3'd4:    len = 6'd38;
      3'd5:    len = 6'd46;
      3'd6:    len = 6'd54;
      3'd7:    len = 6'd62;
      default: len = 6'd12;
    endcase
    return len;
  endfunction

  // Spread the data bits over the positions that are not powers of two.
  function automatic logic [CW_W-1:0] place_data(input logic [ROW_W-1:0] row);
    logic [CW_W-1:0] cw;
    int di;
    cw = '0;
    di = 0;
    for (int pos = 1; pos <= CW_W; pos++) begin
      if ((pos & (pos - 1)) != 0) begin
        cw[pos-1] = row[ROW_W-1-di];
        di++;
      end
    end
    return cw;
  endfunction

  // Even parity over every position whose index has bit d set. Unused upper
  // positions hold zero, so they never change a check bit.
  function automatic logic [CW_W-1:0] add_parity(input logic [CW_W-1:0] data);
    logic [CW_W-1:0] cw;
    logic par;
    cw = data;
    for (int d = 0; d < PAR_W; d++) begin
      par = 1'b0;
      for (int pos = 1; pos <= CW_W; pos++) begin
        if (((pos >> d) & 1) != 0) par = par ^ data[pos-1];
      end
      cw[(1 << d) - 1] = par;
    end
    return cw;
  endfunction

endpackage

>>> rtl/hre_if.sv
// Valid/ready channel interfaces for the byte input and the codeword output.
`timescale 1ns / 1ps
interface hre_in_if;
  logic                        valid;
  logic                        ready;
  logic [hre_pkg::BYTE_W-1:0]  data_byte;
  logic                        end_of_message;

  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface hre_out_if;
  logic                        valid;
  logic                        ready;
  logic [hre_pkg::CW_W-1:0]    codeword;
  logic [hre_pkg::BITS_W-1:0]  codeword_bits;
  logic [hre_pkg::PAD_W-1:0]   pad_bytes;

  modport source (output valid, output codeword, output codeword_bits, output pad_bytes,
                  input ready);
  modport sink   (input valid, input codeword, input codeword_bits, input pad_bytes,
                  output ready);
endinterface

>>> rtl/hre_gather.sv
// Row assembly: collects bytes, pads a short final row and registers the job.
`timescale 1ns / 1ps
module hre_gather (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [hre_pkg::RB_W-1:0] cfg_data,
  hre_in_if.sink                   in_ch,
  output logic                     job_valid,
  input  logic                     job_ready,
  output hre_pkg::job_t            job
);
  import hre_pkg::*;

  logic [RB_W-1:0]   row_bytes_r;
  logic [RB_W-1:0]   held_r, held_nxt;
  logic [ROW_W-1:0]  row_store_r, row_store_nxt;
  logic              job_v_r, job_v_nxt;
  job_t              job_r, job_nxt;

  logic [RB_W-1:0]   rb;
  logic [RB_W-1:0]   n;
  logic              take;
  logic              row_done;
  logic [ROW_W-1:0]  shifted;
  logic [ROW_W-1:0]  aligned;

  assign in_ch.ready = !job_v_r || job_ready;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    rb            = eff_row_bytes(row_bytes_r);
    n             = held_r + RB_W'(1);
    row_store_nxt = {row_store_r[ROW_W-BYTE_W-1:0], in_ch.data_byte};
    row_done      = (n >= rb) || in_ch.end_of_message;

    // Move the n newest bytes to the top, then fill the slots up to the row length.
    shifted = row_store_nxt << {RB_W'(MAX_ROW_BYTES) - n, 3'b000};
    for (int k = 0; k < MAX_ROW_BYTES; k++) begin
      if (k < int'(n)) begin
        aligned[ROW_W-1-BYTE_W*k -: BYTE_W] = shifted[ROW_W-1-BYTE_W*k -: BYTE_W];
      end else if (k < int'(rb)) begin
        aligned[ROW_W-1-BYTE_W*k -: BYTE_W] = FILL_BYTE;
      end else begin
        aligned[ROW_W-1-BYTE_W*k -: BYTE_W] = '0;
      end
    end

    job_nxt            = job_r;
    job_nxt.row        = aligned;
    job_nxt.total_bits = codeword_len(rb);
    job_nxt.pad_bytes  = PAD_W'(rb - n);

    if (cfg_we) begin
      held_nxt = '0;
    end else if (take) begin
      held_nxt = row_done ? '0 : n;
    end else begin
      held_nxt = held_r;
    end

    if (take && row_done) begin
      job_v_nxt = 1'b1;
    end else if (job_ready) begin
      job_v_nxt = 1'b0;
    end else begin
      job_v_nxt = job_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_bytes_r <= RB_W'(1);
      held_r      <= '0;
      job_v_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        row_bytes_r <= cfg_data;
      end
      held_r  <= held_nxt;
      job_v_r <= job_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      row_store_r <= row_store_nxt;
    end
    if (take && row_done) begin
      job_r <= job_nxt;
    end
  end

  assign job_valid = job_v_r;
  assign job       = job_r;

endmodule

>>> rtl/hre_encode.sv
// Codeword stage: places data bits, adds check bits and holds the result.
`timescale 1ns / 1ps
module hre_encode (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_valid,
  output logic          job_ready,
  input  hre_pkg::job_t job,
  hre_out_if.source     out_ch
);
  import hre_pkg::*;

  logic              out_v_r, out_v_nxt;
  logic [CW_W-1:0]   codeword_r, codeword_nxt;
  logic [BITS_W-1:0] bits_r;
  logic [PAD_W-1:0]  pad_r;
  logic              load;

  assign job_ready = !out_v_r || out_ch.ready;
  assign load      = job_valid && job_ready;

  always_comb begin
    codeword_nxt = add_parity(place_data(job.row));
    if (load) begin
      out_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      codeword_r <= codeword_nxt;
      bits_r     <= job.total_bits;
      pad_r      <= job.pad_bytes;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.codeword      = codeword_r;
  assign out_ch.codeword_bits = bits_r;
  assign out_ch.pad_bytes     = pad_r;

endmodule

>>> rtl/hamming_row_encoder.sv
// Top level of the even-parity Hamming row encoder.
//
//   Channel  Direction  Transfer carries
//   in_ch    sink       data_byte, end_of_message
//   out_ch   source     codeword, codeword_bits, pad_bytes
//   cfg_*    write      row_bytes (cfg_we, cfg_data)
//
// One byte is taken in every cycle while out_ch does not stall; the gather stage and
// the encode stage each hold one registered item, so back-to-back transfers run
// at full rate. The row that a byte ends is registered in the job register, then its
// codeword in the output register. A stall on out_ch first fills the output
// register, then the job register, and only then drops in_ch.ready.
// Reset sets the row length to one byte and empties both stages.
`timescale 1ns / 1ps
module hamming_row_encoder (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [hre_pkg::RB_W-1:0] cfg_data,
  hre_in_if.sink                   in_ch,
  hre_out_if.source                out_ch
);
  import hre_pkg::*;

  logic job_valid;
  logic job_ready;
  job_t job;

  hre_gather u_gather (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  hre_encode u_encode (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .out_ch    (out_ch)
  );

endmodule

>>> rtl/hre_checker.sv
// Port-level assertions for the Hamming row encoder, bound to the top level.
`timescale 1ns / 1ps
module hre_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [hre_pkg::CW_W-1:0]   codeword,
  input logic [hre_pkg::BITS_W-1:0] codeword_bits,
  input logic [hre_pkg::PAD_W-1:0]  pad_bytes
);
  import hre_pkg::*;

  // A stalled result keeps its codeword.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(codeword))
    else $error("codeword changed while stalled");

  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // With the output register empty nothing can hold back the input.
  assert property (@(posedge clk) disable iff (!rst_n) !out_valid |-> in_ready)
    else $error("input stalled with an empty output");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (codeword_bits == 6'd12 || codeword_bits == 6'd21 ||
                   codeword_bits == 6'd29 || codeword_bits == 6'd38 ||
                   codeword_bits == 6'd46 || codeword_bits == 6'd54 ||
                   codeword_bits == 6'd62))
    else $error("codeword length is not a valid row size");

  // A one-byte row is always complete, so it never carries filler.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && codeword_bits == 6'd12 |-> pad_bytes == '0)
    else $error("filler reported on a one-byte row");

endmodule

bind hamming_row_encoder hre_checker u_hre_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .codeword      (out_ch.codeword),
  .codeword_bits (out_ch.codeword_bits),
  .pad_bytes     (out_ch.pad_bytes)
);

>>> verif/testbench.sv
// Self-checking testbench for the Hamming row encoder with random traffic and stalls.
`timescale 1ns / 1ps
module testbench;
  import hre_pkg::*;

  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int SHOWN_MISMATCHES = 10;
  localparam int PHASE_ITEMS      = 48;

  typedef struct {
    logic [BYTE_W-1:0] data_byte;
    logic              last;
    logic              drain_first;
  } pending_byte_t;

  typedef struct {
    logic [CW_W-1:0]   codeword;
    logic [BITS_W-1:0] codeword_bits;
    logic [PAD_W-1:0]  pad_bytes;
  } codeword_t;

  typedef enum int {FLOW_FREE, FLOW_HALF, FLOW_SPARSE, FLOW_BLOCKED} flow_mode_t;

  logic            clk = 1'b0;
  logic            rst_n;
  logic            cfg_we;
  logic [RB_W-1:0] cfg_data;

  hre_in_if  in_ch();
  hre_out_if out_ch();

  hamming_row_encoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  pending_byte_t pending_bytes[$];
  codeword_t     codewords_due[$];

  // Local copy of the encoder state, advanced on every input transfer.
  logic [RB_W-1:0]  row_len_setting;
  logic [ROW_W-1:0] gathered_bytes;
  int               bytes_gathered;

  int         mismatches;
  int         burst_left;
  int         gap_left;
  int         stall_left;
  flow_mode_t flow_mode;
  int         quiet_cycles;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int active_row_len(input logic [RB_W-1:0] setting);
    int v;
    v = setting;
    if (v < 1) v = 1;
    if (v > MAX_ROW_BYTES) v = MAX_ROW_BYTES;
    return v;
  endfunction

  // Data bit i (counting from 1) is bit data_bits-i of row_bits.
  function automatic codeword_t hamming_codeword(input logic [63:0] row_bits, input int row_len,
                                                 input int pad);
    codeword_t res;
    int data_bits, checks, total, di;
    logic par;
    data_bits = 8 * row_len;
    checks = 0;
    while (data_bits + checks + 1 > (1 << checks)) checks++;
    total = data_bits + checks;
    res.codeword = '0;
    di = 1;
    for (int pos = 1; pos <= total; pos++) begin
      if ((pos & (pos - 1)) != 0) begin
        res.codeword[pos-1] = row_bits[data_bits-di];
        di++;
      end
    end
    for (int d = 0; (1 << d) <= total; d++) begin
      par = 1'b0;
      for (int pos = 1; pos <= total; pos++) begin
        if (((pos >> d) & 1) != 0) par = par ^ res.codeword[pos-1];
      end
      res.codeword[(1 << d) - 1] = par;
    end
    res.codeword_bits = BITS_W'(total);
    res.pad_bytes = PAD_W'(pad);
    return res;
  endfunction

  function automatic void take_byte(input logic [BYTE_W-1:0] data, input logic last);
    logic [63:0] row;
    int row_len, n, pad;
    row_len = active_row_len(row_len_setting);
    gathered_bytes = {gathered_bytes[ROW_W-BYTE_W-1:0], data};
    n = bytes_gathered + 1;
    if (n < row_len && !last) begin
      bytes_gathered = n;
    end else begin
      if (n > row_len) n = row_len;
      pad = row_len - n;
      row = 64'(gathered_bytes) & ((64'd1 << (8 * n)) - 64'd1);
      for (int i = 0; i < pad; i++) row = {row[55:0], FILL_BYTE};
      codewords_due.push_back(hamming_codeword(row, row_len, pad));
      bytes_gathered = 0;
    end
  endfunction

  function automatic void queue_byte(input logic [BYTE_W-1:0] data, input logic last,
                                     input logic drain_first);
    pending_byte_t item;
    item.data_byte = data;
    item.last = last;
    item.drain_first = drain_first;
    pending_bytes.push_back(item);
  endfunction

  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return FILL_BYTE;
      default: return BYTE_W'($urandom);
    endcase
  endfunction

  // Sampled at the falling edge, after everything from the rising edge has settled.
  task automatic wait_drained();
    while (pending_bytes.size() != 0 || in_ch.valid || codewords_due.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_row_bytes(input logic [RB_W-1:0] value);
    wait_drained();
    // Bytes that complete no row may still sit in the gather stage.
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Predictor: follows register writes and input transfers.
  always @(posedge clk) begin
    if (!rst_n) begin
      row_len_setting = RB_W'(1);
      gathered_bytes = '0;
      bytes_gathered = 0;
    end else begin
      if (cfg_we) begin
        row_len_setting = cfg_data;
        bytes_gathered = 0;
      end
      if (in_ch.valid && in_ch.ready) take_byte(in_ch.data_byte, in_ch.end_of_message);
    end
  end

  // Driver: bursts of transfers separated by random gaps.
  always @(posedge clk) begin
    logic next_valid;
    pending_byte_t item;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      next_valid = in_ch.valid && !in_ch.ready;
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_bytes.size() != 0 &&
                     !(pending_bytes[0].drain_first &&
                       (in_ch.valid || codewords_due.size() != 0))) begin
          item = pending_bytes.pop_front();
          next_valid = 1'b1;
          in_ch.data_byte <= item.data_byte;
          in_ch.end_of_message <= item.last;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end
        end
      end
      in_ch.valid <= next_valid;
    end
  end

  // Receiver: switches between free flow, random and sparse acceptance, and full stalls.
  always @(posedge clk) begin
    logic next_ready;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
      flow_mode = FLOW_FREE;
    end else begin
      if (stall_left == 0) begin
        flow_mode = flow_mode_t'($urandom_range(0, 3));
        stall_left = $urandom_range(4, 48);
      end else begin
        stall_left--;
      end
      case (flow_mode)
        FLOW_FREE:   next_ready = 1'b1;
        FLOW_HALF:   next_ready = 1'($urandom_range(0, 1));
        FLOW_SPARSE: next_ready = ($urandom_range(0, 3) == 0);
        default:     next_ready = 1'b0;
      endcase
      out_ch.ready <= next_ready;
    end
  end

  // Monitor: every codeword transfer is matched against the oldest prediction.
  always @(posedge clk) begin
    codeword_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (codewords_due.size() == 0) begin
        if (mismatches < SHOWN_MISMATCHES)
          $display("unexpected codeword %h bits %0d pad %0d", out_ch.codeword,
                   out_ch.codeword_bits, out_ch.pad_bytes);
        mismatches++;
      end else begin
        want = codewords_due.pop_front();
        if (out_ch.codeword !== want.codeword || out_ch.codeword_bits !== want.codeword_bits ||
            out_ch.pad_bytes !== want.pad_bytes) begin
          if (mismatches < SHOWN_MISMATCHES)
            $display("codeword mismatch: expected %h/%0d/%0d, got %h/%0d/%0d",
                     want.codeword, want.codeword_bits, want.pad_bytes,
                     out_ch.codeword, out_ch.codeword_bits, out_ch.pad_bytes);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles = 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("testbench failed");
        $finish;
      end
    end
  end

  initial begin
    logic [RB_W-1:0] row_settings [0:7];
    int row_len, msg_len, phase_items, msg_count, tail_len;
    logic noisy;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.end_of_message = 1'b0;
    out_ch.ready = 1'b0;
    mismatches = 0;
    row_settings[0] = 3'd3;
    row_settings[1] = 3'd2;
    row_settings[2] = 3'd0;
    row_settings[3] = 3'd5;
    row_settings[4] = 3'd4;
    row_settings[5] = 3'd6;
    row_settings[6] = 3'd7;
    row_settings[7] = 3'd1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: one-byte rows after reset, with and without the final-byte flag.
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'hFF, 1'b0, 1'b0);
    queue_byte(8'h80, 1'b1, 1'b0);
    queue_byte(8'h01, 1'b1, 1'b0);
    write_row_bytes(3'd7);
    // A final byte that fills the row exactly gets no filler.
    for (int i = 0; i < 6; i++) queue_byte(8'hFF, 1'b0, 1'b0);
    queue_byte(8'hFF, 1'b1, 1'b0);
    queue_byte(8'h00, 1'b1, 1'b0);
    queue_byte(8'h5A, 1'b0, 1'b0);
    queue_byte(8'hA5, 1'b0, 1'b0);
    queue_byte(8'h3C, 1'b1, 1'b0);
    // This partial row is dropped by the next register write.
    queue_byte(8'h12, 1'b0, 1'b0);
    queue_byte(8'h34, 1'b0, 1'b0);
    write_row_bytes(3'd0);
    queue_byte(8'hC3, 1'b0, 1'b0);
    queue_byte(8'h7E, 1'b1, 1'b0);

    foreach (row_settings[k]) begin
      write_row_bytes(row_settings[k]);
      row_len = active_row_len(row_settings[k]);
      phase_items = 0;
      msg_count = 0;
      while (phase_items < PHASE_ITEMS) begin
        noisy = ($urandom_range(0, 9) == 0);
        if ($urandom_range(0, 2) == 0) msg_len = row_len * $urandom_range(1, 3);
        else msg_len = $urandom_range(1, 3 * row_len + 1);
        for (int i = 0; i < msg_len; i++) begin
          // The second message of a phase waits until all codewords so far are out.
          queue_byte(pick_byte(),
                     noisy ? ($urandom_range(0, 3) == 0) : (i == msg_len - 1),
                     msg_count == 1 && i == 0);
          phase_items++;
        end
        msg_count++;
      end
      if (row_len > 1 && $urandom_range(0, 1) == 1) begin
        tail_len = $urandom_range(1, row_len - 1);
        for (int i = 0; i < tail_len; i++) queue_byte(pick_byte(), 1'b0, 1'b0);
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    mismatches += codewords_due.size();
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
